>>> rtl/core/pkft_pkg.sv
// Package for the port knock flow table: beat structs, slot layout, state codes,
// register indexes and the knock sequence step function.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pkft_pkg;

    // Configuration register indexes and port widths
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_PORT  = 2'd2;

    localparam logic [15:0] FIRST_PORT_RST  = 16'd100;
    localparam logic [15:0] SECOND_PORT_RST = 16'd101;
    localparam logic [15:0] THIRD_PORT_RST  = 16'd102;

    typedef enum logic [1:0] {
        KS_CLOSED = 2'd0,
        KS_FIRST  = 2'd1,
        KS_SECOND = 2'd2,
        KS_OPEN   = 2'd3
    } t_knock;

    typedef struct packed {
        logic [31:0] source_address;
        logic [15:0] dest_port;
        logic        syn_flag;
        logic        fin_set;
    } t_in_item;

    typedef struct packed {
        logic       pass_verdict;
        logic       entry_hit;
        logic [1:0] knock_state_out;
        logic       insert_failed;
    } t_out_item;

    // One table slot as held in memory
    typedef struct packed {
        logic        vld;
        t_knock      ks;
        logic [31:0] key;
    } t_slot;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_SCAN   = 3'd2,
        ST_DRAIN  = 3'd3,
        ST_UPDATE = 3'd4
    } t_state;

    typedef struct packed {
        logic clear_wr;   // write an empty slot at the sweep address
        logic accept;     // capture the input beat and restart the search
        logic scan_rd;    // read the slot at the sweep address
        logic commit;     // write back the slot and load the result
    } t_ctl_cmd;

    typedef struct packed {
        logic addr_last;  // sweep address is at the last slot
        logic out_busy;   // result register full and not drained this cycle
    } t_ctl_status;

    function automatic t_knock knock_advance(
        input t_knock      cur,
        input logic [15:0] port,
        input logic [15:0] p1,
        input logic [15:0] p2,
        input logic [15:0] p3
    );
        t_knock nxt;
        nxt = KS_CLOSED;
        case (cur)
            KS_CLOSED: if (port == p1) nxt = KS_FIRST;
            KS_FIRST:  if (port == p2) nxt = KS_SECOND;
            KS_SECOND: if (port == p3) nxt = KS_OPEN;
            default:   nxt = KS_CLOSED;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pkft_ctrl.sv
// Controller of the port knock flow table: clearing sweep, search, commit sequence.
// Depends on pkft_pkg for the state enum and the command and status structs.
`default_nettype none

module pkft_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire pkft_pkg::t_ctl_status  i_status,
    output pkft_pkg::t_ctl_cmd          o_cmd
);
    import pkft_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.addr_last) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (i_status.addr_last) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_UPDATE;
            ST_UPDATE: if (!i_status.out_busy) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_UPDATE: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/pkft_dpath.sv
// Datapath of the port knock flow table: slot memory, sweep counter, match and
// free-slot tracking, knock registers and result register. Depends on pkft_pkg.
`default_nettype none

module pkft_dpath #(
    parameter int unsigned TABLE_ENTRIES = 512
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire pkft_pkg::t_in_item              i_in_item,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [pkft_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [pkft_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output pkft_pkg::t_out_item                  o_out_item,
    input  wire pkft_pkg::t_ctl_cmd              i_cmd,
    output pkft_pkg::t_ctl_status                o_status
);
    import pkft_pkg::*;

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    t_slot       r_mem [TABLE_ENTRIES];
    t_slot       r_rdata;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_cmp_addr;
    logic        r_rd_pend;

    t_in_item    r_item;
    logic        r_found;
    logic [AW-1:0] r_found_idx;
    t_knock      r_found_ks;
    logic        r_free;
    logic [AW-1:0] r_free_idx;

    logic [15:0] r_port1;
    logic [15:0] r_port2;
    logic [15:0] r_port3;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        addr_last;
    t_knock      adv_ks;
    t_knock      ins_ks;
    t_knock      res_ks;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    t_slot       mem_wd;
    t_out_item   n_out;

    assign addr_last          = (r_addr == LAST_ADDR);
    assign o_status.addr_last = addr_last;
    assign o_status.out_busy  = r_out_valid && !i_out_ready;
    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

    // Knock registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port1 <= FIRST_PORT_RST;
            r_port2 <= SECOND_PORT_RST;
            r_port3 <= THIRD_PORT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_PORT:  r_port1 <= i_cfg_data;
                CFG_SECOND_PORT: r_port2 <= i_cfg_data;
                CFG_THIRD_PORT:  r_port3 <= i_cfg_data;
                default:         r_port1 <= r_port1;
            endcase
        end
    end

    // Sweep address: wraps back to zero after the last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_rd;
            if (i_cmd.clear_wr || i_cmd.scan_rd) begin
                r_addr <= addr_last ? '0 : r_addr + AW'(1);
            end
        end
    end

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.scan_rd) begin
            r_rdata    <= r_mem[r_addr];
            r_cmp_addr <= r_addr;
        end
    end

    // Capture the beat; track first match and lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else if (i_cmd.accept) begin
            r_found <= 1'b0;
            r_free  <= 1'b0;
        end else if (r_rd_pend) begin
            if (r_rdata.vld) begin
                if (!r_found && (r_rdata.key == r_item.source_address)) begin
                    r_found <= 1'b1;
                end
            end else if (!r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
        end
        if (r_rd_pend && r_rdata.vld && !r_found
                && (r_rdata.key == r_item.source_address)) begin
            r_found_idx <= r_cmp_addr;
            r_found_ks  <= r_rdata.ks;
        end
        if (r_rd_pend && !r_rdata.vld && !r_free) begin
            r_free_idx <= r_cmp_addr;
        end
    end

    // Update and result
    always_comb begin
        adv_ks = knock_advance(r_found_ks, r_item.dest_port, r_port1, r_port2, r_port3);
        ins_ks = (r_item.dest_port == r_port1) ? KS_FIRST : KS_CLOSED;

        if (r_found) begin
            res_ks = adv_ks;
        end else if (r_item.syn_flag && r_free) begin
            res_ks = ins_ks;
        end else begin
            res_ks = KS_CLOSED;
        end

        n_out.pass_verdict    = r_found && (adv_ks == KS_OPEN);
        n_out.entry_hit       = r_found;
        n_out.knock_state_out = res_ks;
        n_out.insert_failed   = !r_found && r_item.syn_flag && !r_free;

        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        if (i_cmd.clear_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.commit) begin
            mem_we     = r_found || (r_item.syn_flag && r_free);
            mem_wa     = r_found ? r_found_idx : r_free_idx;
            mem_wd.vld = r_found ? !r_item.fin_set : 1'b1;
            mem_wd.ks  = res_ks;
            mem_wd.key = r_item.source_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/port_knock_flow_table.sv
// Top level of the port knock flow table: controller plus datapath.
// Depends on pkft_pkg, pkft_ctrl and pkft_dpath.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | i_in_valid/o_in_ready   | i_in_item  (address, port, SYN, FIN)
//  out     | o_out_valid/i_out_ready | o_out_item (verdict, hit, state, fail)
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data (knock ports)
//
// Sequence: from one accept to the next, a beat passes through the accept state,
// the search that reads one slot per cycle through the single read port of the
// slot memory, then a drain state and a commit state.
// Reset: a clearing pass through every slot marks each slot empty;
// input beats wait until it ends, configuration writes are taken throughout.
// Stalls: the result register holds a finished beat while the next one is
// accepted and searched; commit waits only if that register is still full.
`default_nettype none

module port_knock_flow_table #(
    parameter int unsigned TABLE_ENTRIES = 512
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire pkft_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output pkft_pkg::t_out_item              o_out_item,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [pkft_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [pkft_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pkft_pkg::*;

    t_ctl_cmd    cmd;
    t_ctl_status status;

    // Sequence the clearing pass, the search and the commit
    pkft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold the table, the knock ports and the result beat
    pkft_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_status    (status)
    );

`ifndef ASSERT_OFF
    // Commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear_wr, cmd.accept, cmd.scan_rd, cmd.commit}))
        else $error("controller issued overlapping commands");

    // Search starts on the cycle after an accepted beat, at slot zero
    a_scan_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> (cmd.scan_rd && !status.addr_last) || (TABLE_ENTRIES == 1))
        else $error("search did not start after accept");

    // Never overwrite a result beat that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_out_valid && !i_out_ready))
        else $error("result register overwritten");

    // No commit right after an accept: a full search lies between
    a_no_early_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !cmd.commit)
        else $error("commit without search");
`endif

endmodule

`default_nettype wire
